// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the quaternion-to-Euler RTL, used by its queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/qea_pkg.sv =====
// Package with the widths, constants, types and arctangent table of the converter.
`timescale 1ns / 1ps
package qea_pkg;

    // Field widths
    localparam int QUAT_W  = 16;
    localparam int PITCH_W = 15;
    localparam int ANGLE_W = 16;

    // Algorithm constants
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int TABLE_LEN       = 24;

    // Internal widths
    localparam int PROD_W  = 2 * QUAT_W;
    localparam int OPER_W  = PROD_W + 2;
    localparam int SMALL_W = 29;
    localparam int ROOT_W  = 29;
    localparam int RAD_W   = 57;
    localparam int TRY_W   = 2 * ROOT_W + 2;
    localparam int NORM_W  = OPER_W + 1;
    localparam int MAG_W   = OPER_W;
    localparam int NORM_EXP    = 32;
    localparam int NORM_STAGES = 6;
    localparam int CORD_W  = OPER_W + 4;
    localparam int ACC_W   = 40;
    localparam int QUO_BITS = 8 + ANGLE_FRAC_BITS;
    localparam int RES_W   = QUO_BITS + 1;
    localparam int NUM_W   = ACC_W + ANGLE_FRAC_BITS;

    // Division by one degree: 1e9 = 2^9 * 1953125, odd factor by reciprocal
    localparam int DEG_POW2   = 9;
    localparam int DQ_W       = 21 + QUO_BITS;
    localparam int LO_SH      = 15;
    localparam int HI_W       = DQ_W - LO_SH;
    localparam int RCP_W      = 24;
    localparam int RECIP_SH   = QUO_BITS + 7;
    localparam int DIV_STAGES = 2;

    // Pipeline depths
    localparam int ATAN_LAT   = 1 + NORM_STAGES + 1 + CORDIC_STEPS + 1 + DIV_STAGES + 1;
    localparam int PRE_LAT    = ROOT_W + 2;
    localparam int FIFO_DEPTH = 2;

    // Fixed-point constants
    localparam logic signed [OPER_W-1:0] ONE_Q28 = OPER_W'(64'sd1 <<< 28);
    localparam logic [RAD_W-1:0] ONE_Q56 = RAD_W'(1) << 56;
    localparam logic signed [ACC_W-1:0] QUARTER_NANO = ACC_W'(64'sd90000000000);
    localparam logic [NUM_W-1:0] NANO_PER_DEG = NUM_W'(64'd1000000000);
    localparam logic [NUM_W-1:0] HALF_NANO = NUM_W'(64'd500000000);
    localparam logic signed [PITCH_W-1:0] PITCH_CLAMP = PITCH_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [DQ_W-1:0] DEG_ODD = DQ_W'(NANO_PER_DEG >> DEG_POW2);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << (LO_SH + RECIP_SH)) / 64'd1953125);

    // One decoded quaternion on its way from the front end to the angle engine
    typedef struct packed {
        logic signed [OPER_W-1:0] s;
        logic                     clamp;
        logic signed [OPER_W-1:0] yaw_y;
        logic signed [OPER_W-1:0] yaw_x;
        logic signed [OPER_W-1:0] roll_y;
        logic signed [OPER_W-1:0] roll_x;
    } item_t;

    // atan(2^-i) in units of 1e-9 degree
    function automatic logic signed [ACC_W-1:0] atan_nano(input int idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            0:  v = ACC_W'(64'sd45000000000);
            1:  v = ACC_W'(64'sd26565051177);
            2:  v = ACC_W'(64'sd14036243468);
            3:  v = ACC_W'(64'sd7125016349);
            4:  v = ACC_W'(64'sd3576334375);
            5:  v = ACC_W'(64'sd1789910608);
            6:  v = ACC_W'(64'sd895173710);
            7:  v = ACC_W'(64'sd447614171);
            8:  v = ACC_W'(64'sd223810500);
            9:  v = ACC_W'(64'sd111905677);
            10: v = ACC_W'(64'sd55952892);
            11: v = ACC_W'(64'sd27976453);
            12: v = ACC_W'(64'sd13988227);
            13: v = ACC_W'(64'sd6994114);
            14: v = ACC_W'(64'sd3497057);
            15: v = ACC_W'(64'sd1748528);
            16: v = ACC_W'(64'sd874264);
            17: v = ACC_W'(64'sd437132);
            18: v = ACC_W'(64'sd218566);
            19: v = ACC_W'(64'sd109283);
            20: v = ACC_W'(64'sd54642);
            21: v = ACC_W'(64'sd27321);
            22: v = ACC_W'(64'sd13660);
            23: v = ACC_W'(64'sd6830);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/qea_front.sv =====
// Front end: accepts quaternions, forms the products, the pitch term and the atan2 operands.
`timescale 1ns / 1ps
module qea_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [qea_pkg::QUAT_W-1:0]  s_quat_x,
    input  logic signed [qea_pkg::QUAT_W-1:0]  s_quat_y,
    input  logic signed [qea_pkg::QUAT_W-1:0]  s_quat_z,
    input  logic signed [qea_pkg::QUAT_W-1:0]  s_quat_w,
    output logic                               out_valid,
    input  logic                               out_ready,
    output qea_pkg::item_t                     out_item
);
    import qea_pkg::*;

    logic adv;
    logic p1_valid_reg;
    logic p2_valid_reg;
    logic signed [PROD_W-1:0] wx_reg, yz_reg, xz_reg, wy_reg, xy_reg, zw_reg;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    item_t item_reg;
    item_t item_next;

    // Advance both stages unless the last one is blocked by the queue
    assign adv       = !p2_valid_reg || out_ready;
    assign s_ready   = adv;
    assign out_valid = p2_valid_reg;
    assign out_item  = item_reg;

    // Hold stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // Form all component products
    always_ff @(posedge aclk) begin
        if (adv) begin
            wx_reg <= s_quat_w * s_quat_x;
            yz_reg <= s_quat_y * s_quat_z;
            xz_reg <= s_quat_x * s_quat_z;
            wy_reg <= s_quat_w * s_quat_y;
            xy_reg <= s_quat_x * s_quat_y;
            zw_reg <= s_quat_z * s_quat_w;
            xx_reg <= s_quat_x * s_quat_x;
            yy_reg <= s_quat_y * s_quat_y;
            zz_reg <= s_quat_z * s_quat_z;
            ww_reg <= s_quat_w * s_quat_w;
        end
    end

    // Sum products into pitch term and operands, classify the pitch term
    always_comb begin
        item_next.s      = (OPER_W'(wx_reg) - OPER_W'(yz_reg)) <<< 1;
        item_next.yaw_y  = (OPER_W'(xz_reg) + OPER_W'(wy_reg)) <<< 1;
        item_next.yaw_x  = OPER_W'(zz_reg) + OPER_W'(ww_reg) - OPER_W'(xx_reg) - OPER_W'(yy_reg);
        item_next.roll_y = (OPER_W'(xy_reg) + OPER_W'(zw_reg)) <<< 1;
        item_next.roll_x = OPER_W'(yy_reg) + OPER_W'(ww_reg) - OPER_W'(xx_reg) - OPER_W'(zz_reg);
        item_next.clamp  = (item_next.s >= ONE_Q28) || (item_next.s <= -ONE_Q28);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/core/qea_fifo.sv =====
// Short queue that decouples the front end from the angle engine.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qea_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  qea_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output qea_pkg::item_t pop_item
);
    import qea_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    item_t mem_reg [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic push_fire;
    logic pop_fire;

    assign push_ready = (count_reg != (PTR_W+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Store entries
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_count_range, aclk, aresetn, count_reg > (PTR_W+1)'(FIFO_DEPTH), "queue count out of range")
    `ASSERT_CLK(a_drain_last, aclk, aresetn, (pop_fire && !push_fire && count_reg == 1) |=> !pop_valid, "queue not empty after last transaction left")
    `ASSERT_CLK(a_count_up, aclk, aresetn, (push_fire && !pop_fire) |=> count_reg == $past(count_reg) + 1'b1, "queue count did not follow a push")

endmodule

// ===== rtl/core/qea_atan2.sv =====
// One atan2 lane: normalization, quadrant fold, CORDIC vectoring and rounding to degree units.
`timescale 1ns / 1ps
module qea_atan2 (
    input  logic                              aclk,
    input  logic                              adv,
    input  logic signed [qea_pkg::OPER_W-1:0] y_in,
    input  logic signed [qea_pkg::OPER_W-1:0] x_in,
    output logic signed [qea_pkg::RES_W-1:0]  angle_out
);
    import qea_pkg::*;

    logic signed [NORM_W-1:0] nx_reg [0:NORM_STAGES];
    logic signed [NORM_W-1:0] ny_reg [0:NORM_STAGES];
    logic [MAG_W-1:0] mx_reg [0:NORM_STAGES-1];
    logic [MAG_W-1:0] my_reg [0:NORM_STAGES-1];
    logic zf_reg [0:ATAN_LAT-2];
    logic signed [CORD_W-1:0] cx_reg [0:CORDIC_STEPS-1];
    logic signed [CORD_W-1:0] cy_reg [0:CORDIC_STEPS-1];
    logic signed [ACC_W-1:0]  acc_reg [0:CORDIC_STEPS];
    logic [NUM_W-1:0]      num_reg;
    logic [DQ_W-1:0]       dq_reg;
    logic [QUO_BITS-1:0]   qest_reg;
    logic [QUO_BITS-1:0]   quo_reg;
    logic                  neg_reg [0:DIV_STAGES];
    logic [HI_W-1:0]       num_hi;
    logic [HI_W+RCP_W-1:0] est_prod;
    logic [DQ_W-1:0]       back_prod;
    logic [DQ_W-1:0]       rem_val;
    logic signed [RES_W-1:0] res_reg;
    logic signed [CORD_W-1:0] qx;
    logic signed [CORD_W-1:0] qy;
    logic [ACC_W-1:0] acc_mag;

    // Capture operands and their magnitudes
    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg[0] <= NORM_W'(x_in);
            ny_reg[0] <= NORM_W'(y_in);
            mx_reg[0] <= x_in[OPER_W-1] ? MAG_W'(-x_in) : MAG_W'(x_in);
            my_reg[0] <= y_in[OPER_W-1] ? MAG_W'(-y_in) : MAG_W'(y_in);
        end
    end

    // Carry the both-zero flag down the lane
    always_ff @(posedge aclk) begin
        if (adv) begin
            zf_reg[0] <= (x_in == '0) && (y_in == '0);
            for (int k = 1; k <= ATAN_LAT-2; k++) begin
                zf_reg[k] <= zf_reg[k-1];
            end
        end
    end

    // Scale both operands up by powers of two until the larger reaches 2^32
    for (genvar j = 1; j <= NORM_STAGES; j++) begin : g_norm
        localparam int SH = 1 << (NORM_STAGES - j);
        localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (NORM_EXP + 1 - SH);
        logic do_shift;
        assign do_shift = (mx_reg[j-1] < LIM) && (my_reg[j-1] < LIM);
        always_ff @(posedge aclk) begin
            if (adv) begin
                nx_reg[j] <= do_shift ? (nx_reg[j-1] <<< SH) : nx_reg[j-1];
                ny_reg[j] <= do_shift ? (ny_reg[j-1] <<< SH) : ny_reg[j-1];
            end
        end
        if (j < NORM_STAGES) begin : g_mag
            always_ff @(posedge aclk) begin
                if (adv) begin
                    mx_reg[j] <= do_shift ? (mx_reg[j-1] << SH) : mx_reg[j-1];
                    my_reg[j] <= do_shift ? (my_reg[j-1] << SH) : my_reg[j-1];
                end
            end
        end
    end

    // Turn left half plane vectors by a quarter turn
    assign qx = CORD_W'(nx_reg[NORM_STAGES]);
    assign qy = CORD_W'(ny_reg[NORM_STAGES]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (qx < 0) begin
                if (qy >= 0) begin
                    cx_reg[0]  <= qy;
                    cy_reg[0]  <= -qx;
                    acc_reg[0] <= QUARTER_NANO;
                end else begin
                    cx_reg[0]  <= -qy;
                    cy_reg[0]  <= qx;
                    acc_reg[0] <= -QUARTER_NANO;
                end
            end else begin
                cx_reg[0]  <= qx;
                cy_reg[0]  <= qy;
                acc_reg[0] <= '0;
            end
        end
    end

    // CORDIC vectoring iterations, one per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [ACC_W-1:0] ATAN_I = atan_nano(i);
        always_ff @(posedge aclk) begin
            if (adv) begin
                acc_reg[i+1] <= (cy_reg[i] >= 0) ? acc_reg[i] + ATAN_I : acc_reg[i] - ATAN_I;
            end
        end
        if (i < CORDIC_STEPS-1) begin : g_xy
            logic signed [CORD_W-1:0] dx;
            logic signed [CORD_W-1:0] dy;
            assign dx = cx_reg[i] >>> i;
            assign dy = cy_reg[i] >>> i;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (cy_reg[i] >= 0) begin
                        cx_reg[i+1] <= cx_reg[i] + dy;
                        cy_reg[i+1] <= cy_reg[i] - dx;
                    end else begin
                        cx_reg[i+1] <= cx_reg[i] - dy;
                        cy_reg[i+1] <= cy_reg[i] + dx;
                    end
                end
            end
        end
    end

    // Scale the angle magnitude to output units and add half a unit for rounding
    assign acc_mag = acc_reg[CORDIC_STEPS][ACC_W-1] ? ACC_W'(-acc_reg[CORDIC_STEPS])
                                                     : ACC_W'(acc_reg[CORDIC_STEPS]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg    <= (NUM_W'(acc_mag) << ANGLE_FRAC_BITS) + HALF_NANO;
            neg_reg[0] <= acc_reg[CORDIC_STEPS][ACC_W-1];
        end
    end

    // Drop the power-of-two factor, estimate the quotient from the upper bits
    assign num_hi   = num_reg[DEG_POW2+LO_SH +: HI_W];
    assign est_prod = (HI_W+RCP_W)'(num_hi) * (HI_W+RCP_W)'(RECIP);

    always_ff @(posedge aclk) begin
        if (adv) begin
            dq_reg     <= num_reg[DEG_POW2 +: DQ_W];
            qest_reg   <= est_prod[RECIP_SH +: QUO_BITS];
            neg_reg[1] <= neg_reg[0];
        end
    end

    // Correct the estimate, which is low by at most one
    assign back_prod = DQ_W'(qest_reg) * DEG_ODD;
    assign rem_val   = dq_reg - back_prod;

    always_ff @(posedge aclk) begin
        if (adv) begin
            quo_reg    <= (rem_val >= DEG_ODD) ? qest_reg + 1'b1 : qest_reg;
            neg_reg[2] <= neg_reg[1];
        end
    end

    // Apply sign, force zero for a zero vector
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (zf_reg[ATAN_LAT-2]) begin
                res_reg <= '0;
            end else if (neg_reg[DIV_STAGES]) begin
                res_reg <= -RES_W'(quo_reg);
            end else begin
                res_reg <= RES_W'(quo_reg);
            end
        end
    end

    assign angle_out = res_reg;

endmodule

// ===== rtl/core/qea_back.sv =====
// Angle engine: pitch square root, three atan2 lanes and the result register.
`timescale 1ns / 1ps
module qea_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  qea_pkg::item_t                     in_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [qea_pkg::PITCH_W-1:0] m_pitch_deg,
    output logic signed [qea_pkg::ANGLE_W-1:0] m_yaw_deg,
    output logic signed [qea_pkg::ANGLE_W-1:0] m_roll_deg,
    output logic                               m_pitch_clamped
);
    import qea_pkg::*;

    localparam int VLD_N = PRE_LAT + ATAN_LAT;

    logic adv;
    logic vld_reg [0:VLD_N-1];
    logic m_valid_reg;
    item_t it_reg [0:ROOT_W+1];
    logic [RAD_W-1:0]  rem_reg [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic clamp_line_reg [0:ATAN_LAT-1];
    logic sneg_line_reg [0:ATAN_LAT-1];
    logic signed [SMALL_W-1:0] s_small;
    logic signed [2*SMALL_W-1:0] s_sq;
    logic [RAD_W-1:0] c2;
    logic signed [OPER_W-1:0] pitch_y;
    logic signed [OPER_W-1:0] pitch_x;
    logic signed [RES_W-1:0] pitch_res;
    logic signed [RES_W-1:0] yaw_res;
    logic signed [RES_W-1:0] roll_res;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic signed [ANGLE_W-1:0] yaw_reg;
    logic signed [ANGLE_W-1:0] roll_reg;
    logic clamped_reg;
    item_t last_item;

    // Move the whole pipeline unless the result register is held
    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;

    // Advance valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < VLD_N; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < VLD_N; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_valid_reg <= vld_reg[VLD_N-1];
        end
    end

    // Square the pitch term and form 1 - s^2
    assign s_small = it_reg[0].clamp ? '0 : it_reg[0].s[SMALL_W-1:0];
    assign s_sq    = s_small * s_small;
    assign c2      = ONE_Q56 - s_sq[RAD_W-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            it_reg[0]   <= in_item;
            it_reg[1]   <= it_reg[0];
            rem_reg[0]  <= c2;
            root_reg[0] <= '0;
        end
    end

    // Integer square root, one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [TRY_W-1:0] trial;
        logic fits;
        assign trial = (TRY_W'(root_reg[k]) << (B + 1)) + (TRY_W'(1) << (2 * B));
        assign fits  = (TRY_W'(rem_reg[k]) >= trial);
        always_ff @(posedge aclk) begin
            if (adv) begin
                it_reg[k+2]   <= it_reg[k+1];
                root_reg[k+1] <= fits ? (root_reg[k] | (ROOT_W'(1) << B)) : root_reg[k];
            end
        end
        if (k < ROOT_W-1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[k+1] <= fits ? (rem_reg[k] - RAD_W'(trial)) : rem_reg[k];
                end
            end
        end
    end

    // Feed the three lanes together
    assign last_item = it_reg[ROOT_W+1];
    assign pitch_y   = last_item.clamp ? '0 : last_item.s;
    assign pitch_x   = OPER_W'(root_reg[ROOT_W]);

    qea_atan2 u_pitch (
        .aclk      (aclk),
        .adv       (adv),
        .y_in      (pitch_y),
        .x_in      (pitch_x),
        .angle_out (pitch_res)
    );

    qea_atan2 u_yaw (
        .aclk      (aclk),
        .adv       (adv),
        .y_in      (last_item.yaw_y),
        .x_in      (last_item.yaw_x),
        .angle_out (yaw_res)
    );

    qea_atan2 u_roll (
        .aclk      (aclk),
        .adv       (adv),
        .y_in      (last_item.roll_y),
        .x_in      (last_item.roll_x),
        .angle_out (roll_res)
    );

    // Carry the clamp decision alongside the lanes
    always_ff @(posedge aclk) begin
        if (adv) begin
            clamp_line_reg[0] <= last_item.clamp;
            sneg_line_reg[0]  <= last_item.s[OPER_W-1];
            for (int k = 1; k < ATAN_LAT; k++) begin
                clamp_line_reg[k] <= clamp_line_reg[k-1];
                sneg_line_reg[k]  <= sneg_line_reg[k-1];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (clamp_line_reg[ATAN_LAT-1]) begin
                pitch_reg <= sneg_line_reg[ATAN_LAT-1] ? -PITCH_CLAMP : PITCH_CLAMP;
            end else begin
                pitch_reg <= PITCH_W'(pitch_res);
            end
            yaw_reg     <= ANGLE_W'(yaw_res);
            roll_reg    <= ANGLE_W'(roll_res);
            clamped_reg <= clamp_line_reg[ATAN_LAT-1];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pitch_deg     = pitch_reg;
    assign m_yaw_deg       = yaw_reg;
    assign m_roll_deg      = roll_reg;
    assign m_pitch_clamped = clamped_reg;

endmodule

// ===== rtl/core/quaternion_to_euler_angles.sv =====
// Top level of the quaternion to Euler angle (YXZ) converter.
// Takes one Q1.14 quaternion per cycle and returns pitch, yaw and roll in 1/128 degree.
// A quaternion passes through the front end's product and operand registers, the queue, and
// the angle engine (input capture, square, 29 square root bit stages, 28 atan2 lane stages
// of which 16 are CORDIC iterations and 2 divide by one degree, and the result register).
// Throughput is one quaternion per cycle while m_ready stays high; a stalled output freezes
// the angle engine and the two-entry queue absorbs the front end until s_ready drops.
`timescale 1ns / 1ps
module quaternion_to_euler_angles (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [qea_pkg::QUAT_W-1:0]  s_quat_x,
    input  logic signed [qea_pkg::QUAT_W-1:0]  s_quat_y,
    input  logic signed [qea_pkg::QUAT_W-1:0]  s_quat_z,
    input  logic signed [qea_pkg::QUAT_W-1:0]  s_quat_w,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [qea_pkg::PITCH_W-1:0] m_pitch_deg,
    output logic signed [qea_pkg::ANGLE_W-1:0] m_yaw_deg,
    output logic signed [qea_pkg::ANGLE_W-1:0] m_roll_deg,
    output logic                               m_pitch_clamped
);
    import qea_pkg::*;

    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    qea_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_quat_x  (s_quat_x),
        .s_quat_y  (s_quat_y),
        .s_quat_z  (s_quat_z),
        .s_quat_w  (s_quat_w),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    qea_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    qea_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (q_valid),
        .in_ready        (q_ready),
        .in_item         (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pitch_deg     (m_pitch_deg),
        .m_yaw_deg       (m_yaw_deg),
        .m_roll_deg      (m_roll_deg),
        .m_pitch_clamped (m_pitch_clamped)
    );

endmodule
